/* design/ssum_pkg.sv */
// Shared constants and types for the sorted set union merger.
package ssum_pkg;

  localparam int VALUE_W        = 64;
  localparam int OP_W           = 2;
  localparam int LIST_DEPTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND_A = 2'd1,
    OP_APPEND_B = 2'd2,
    OP_PULL     = 2'd3
  } op_t;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

/* design/sorted_set_union_merge.sv */
// Sorted set union merger: two list buffers and a one-pass merge stage.
// An item transferred in is held in the input register, and its result is loaded
// into the result register when the merge stage fires.
// Throughput: one item per cycle while the result channel does not stall, set by the
// single merge stage that compares both list heads and updates the read positions in the same cycle.
// Reset clears the counts, read positions and pipeline valid flags; the list
// memories are not cleared and need no sweep, since only written entries are read.
module sorted_set_union_merge #(
  parameter int LIST_DEPTH = ssum_pkg::LIST_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ssum_pkg::OP_W-1:0]           op,
  input  logic signed [ssum_pkg::VALUE_W-1:0] value,
  // Result channel.
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [ssum_pkg::VALUE_W-1:0] out_value,
  output logic                                out_valid,
  output logic                                out_last,
  output logic                                overflow
);

  // Address width for the list memories and count width able to hold the depth.
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  // Input register.
  logic              q_valid;
  ssum_pkg::op_t     q_op;
  ssum_pkg::value_t  q_value;

  // List memories and the registered head entry of each list. The head register
  // always holds the entry at the list's current read position.
  ssum_pkg::value_t  mem_a [LIST_DEPTH];
  ssum_pkg::value_t  mem_b [LIST_DEPTH];
  ssum_pkg::value_t  head_a;
  ssum_pkg::value_t  head_b;

  logic [CW-1:0]     count_a;
  logic [CW-1:0]     count_b;
  logic [CW-1:0]     read_pos_a;
  logic [CW-1:0]     read_pos_b;
  logic [CW-1:0]     count_a_next;
  logic [CW-1:0]     count_b_next;
  logic [CW-1:0]     read_pos_a_next;
  logic [CW-1:0]     read_pos_b_next;

  logic              wr_a;
  logic              wr_b;
  logic              has_a;
  logic              has_b;
  logic              out_ready;
  logic              proc;

  ssum_pkg::value_t  res_value_next;
  logic              res_elem_next;
  logic              res_last_next;
  logic              res_ovf_next;

  // The merge stage fires when the input register holds an item and the result
  // register is empty or its result is being transferred out this cycle.
  assign out_ready = !res_valid || !res_stall;
  assign proc      = q_valid && out_ready;
  assign in_stall  = q_valid && !out_ready;

  // A list has a head while its read position is below its count.
  assign has_a = read_pos_a < count_a;
  assign has_b = read_pos_b < count_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      q_op    <= ssum_pkg::op_t'(op);
      q_value <= value;
    end
  end

  // Op decode: clear, appends with a full check, and the signed head compares of a pull.
  always_comb begin
    count_a_next    = count_a;
    count_b_next    = count_b;
    read_pos_a_next = read_pos_a;
    read_pos_b_next = read_pos_b;
    wr_a            = 1'b0;
    wr_b            = 1'b0;
    res_value_next  = '0;
    res_elem_next   = 1'b0;
    res_last_next   = 1'b0;
    res_ovf_next    = 1'b0;
    if (proc) begin
      unique case (q_op)
        ssum_pkg::OP_CLEAR: begin
          count_a_next    = '0;
          count_b_next    = '0;
          read_pos_a_next = '0;
          read_pos_b_next = '0;
        end
        ssum_pkg::OP_APPEND_A: begin
          if (count_a == CW'(LIST_DEPTH)) begin
            res_ovf_next = 1'b1;
          end else begin
            wr_a         = 1'b1;
            count_a_next = count_a + CW'(1);
          end
        end
        ssum_pkg::OP_APPEND_B: begin
          if (count_b == CW'(LIST_DEPTH)) begin
            res_ovf_next = 1'b1;
          end else begin
            wr_b         = 1'b1;
            count_b_next = count_b + CW'(1);
          end
        end
        ssum_pkg::OP_PULL: begin
          if (has_a && has_b) begin
            res_elem_next = 1'b1;
            if (head_a == head_b) begin
              // Equal heads give one copy and both lists move on.
              res_value_next  = head_a;
              read_pos_a_next = read_pos_a + CW'(1);
              read_pos_b_next = read_pos_b + CW'(1);
            end else if (head_a < head_b) begin
              res_value_next  = head_a;
              read_pos_a_next = read_pos_a + CW'(1);
            end else begin
              res_value_next  = head_b;
              read_pos_b_next = read_pos_b + CW'(1);
            end
          end else if (has_a) begin
            res_elem_next   = 1'b1;
            res_value_next  = head_a;
            read_pos_a_next = read_pos_a + CW'(1);
          end else if (has_b) begin
            res_elem_next   = 1'b1;
            res_value_next  = head_b;
            read_pos_b_next = read_pos_b + CW'(1);
          end
          // The element is the last one when both lists are now used up.
          res_last_next = res_elem_next && (read_pos_a_next >= count_a) &&
                          (read_pos_b_next >= count_b);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      read_pos_a <= '0;
      read_pos_b <= '0;
    end else begin
      count_a    <= count_a_next;
      count_b    <= count_b_next;
      read_pos_a <= read_pos_a_next;
      read_pos_b <= read_pos_b_next;
    end
  end

  // Memory write at the count, registered read at the next read position. When
  // an append lands on the entry being fetched, the new value goes straight to
  // the head register.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[count_a[AW-1:0]] <= q_value;
    end
    if (wr_a && (count_a == read_pos_a_next)) begin
      head_a <= q_value;
    end else begin
      head_a <= mem_a[read_pos_a_next[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[count_b[AW-1:0]] <= q_value;
    end
    if (wr_b && (count_b == read_pos_b_next)) begin
      head_b <= q_value;
    end else begin
      head_b <= mem_b[read_pos_b_next[AW-1:0]];
    end
  end

  // Result register; a waiting result is held until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= q_valid;
    end
    if (proc) begin
      out_value <= res_value_next;
      out_valid <= res_elem_next;
      out_last  <= res_last_next;
      overflow  <= res_ovf_next;
    end
  end

  // Read positions never pass their list's fill count.
  assert property (@(posedge clk) disable iff (rst) read_pos_a <= count_a)
    else $error("read position of list A beyond its count");
  assert property (@(posedge clk) disable iff (rst) read_pos_b <= count_b)
    else $error("read position of list B beyond its count");

  // A pull that ends the union leaves both lists used up.
  assert property (@(posedge clk) disable iff (rst)
    proc && res_last_next |=> (read_pos_a == count_a) && (read_pos_b == count_b))
    else $error("last element emitted while a list still has entries");

  // A result never carries both an element and an overflow flag.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(out_valid && overflow))
    else $error("result flags an element and an overflow together");

  // The input side only stalls while an item sits in the input register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> q_valid)
    else $error("input stalled with an empty input register");

endmodule
